FILE: hdl/msw_pkg.sv
// Package: shared constants, types and codes of the heartbeat watchdog.
`timescale 1ns / 1ps
package msw_pkg;

  // Table geometry
  localparam int SESSION_SLOTS = 8;
  localparam int AGE_BITS      = 16;

  // Fixed field widths
  localparam int CMD_BITS     = 2;
  localparam int SESSION_BITS = 3;
  localparam int CFG_BITS     = 16;
  localparam int CFG_IDX_BITS = 4;
  localparam int EXP_BITS     = 4;

  // Derived widths
  localparam int COUNT_BITS = $clog2(SESSION_SLOTS + 1);
  localparam int CMP_BITS   = (AGE_BITS > CFG_BITS) ? AGE_BITS : CFG_BITS;

  typedef enum logic [CMD_BITS-1:0] {
    CMD_TICK  = 2'd0,
    CMD_FEED  = 2'd1,
    CMD_UNREG = 2'd2
  } cmd_e;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_TIMEOUT = 4'd0,
    REG_PERIOD  = 4'd1
  } reg_idx_e;

  localparam logic [CFG_BITS-1:0] TIMEOUT_RESET = 16'd200;
  localparam logic [CFG_BITS-1:0] PERIOD_RESET  = 16'd50;

  // Slot table status toward the control logic
  typedef struct packed {
    logic                  present;   // some slot valid when the check looks
    logic                  survivor;  // some valid slot below the timeout
    logic                  any_active;
    logic [COUNT_BITS-1:0] removed;
  } slot_status_t;

endpackage

FILE: hdl/msw_if.sv
// Interfaces: command, result and configuration channels.
`timescale 1ns / 1ps

interface msw_cmd_if;
  import msw_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [CMD_BITS-1:0]     command;
  logic [SESSION_BITS-1:0] session;
  modport source (output valid, command, session, input ready);
  modport sink   (input valid, command, session, output ready);
endinterface

interface msw_res_if;
  import msw_pkg::*;
  logic                valid;
  logic                ready;
  logic                heartbeat_pulse;
  logic                emergency_stop;
  logic                emergency_latched;
  logic                any_active;
  logic [EXP_BITS-1:0] expired_count;
  modport source (output valid, heartbeat_pulse, emergency_stop, emergency_latched,
                  any_active, expired_count, input ready);
  modport sink   (input valid, heartbeat_pulse, emergency_stop, emergency_latched,
                  any_active, expired_count, output ready);
endinterface

interface msw_cfg_if;
  import msw_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [CFG_IDX_BITS-1:0] index;
  logic [CFG_BITS-1:0]     data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: hdl/msw_check_timer.sv
// Check timer: counts ticks and flags when an expiry check is due.
`timescale 1ns / 1ps
module msw_check_timer
  import msw_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                tick_i,    // a tick transaction is processed now
  input  logic [CFG_BITS-1:0] period_i,
  output logic                check_o
);

  logic [CFG_BITS-1:0] cnt_q, cnt_d;
  logic [CFG_BITS-1:0] cnt_inc;
  logic [CFG_BITS-1:0] period;

  always_comb begin
    period  = (period_i == '0) ? CFG_BITS'(1) : period_i;
    cnt_inc = cnt_q + CFG_BITS'(1);  // wraps like the 16-bit counter
    check_o = tick_i && (cnt_inc >= period);
    cnt_d   = cnt_q;
    if (tick_i) begin
      cnt_d = check_o ? '0 : cnt_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

endmodule

FILE: hdl/msw_slot_table.sv
// Slot table: per-slot valid bit and saturating age, aging and expiry compare.
`timescale 1ns / 1ps
module msw_slot_table
  import msw_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  logic [CMD_BITS-1:0]     command_i,
  input  logic [SESSION_BITS-1:0] session_i,
  input  logic                    check_i,
  input  logic [CFG_BITS-1:0]     timeout_i,
  output slot_status_t            status_o
);

  localparam logic [AGE_BITS-1:0] AGE_TOP = '1;

  logic [SESSION_SLOTS-1:0] valid_q, valid_d;
  logic [AGE_BITS-1:0]      age_q [SESSION_SLOTS];
  logic [AGE_BITS-1:0]      age_d [SESSION_SLOTS];
  logic [SESSION_SLOTS-1:0] expire;
  logic [SESSION_SLOTS-1:0] hit;

  always_comb begin
    logic [AGE_BITS-1:0]   aged;
    logic [COUNT_BITS-1:0] removed;
    aged    = '0;
    removed = '0;
    valid_d = valid_q;
    for (int i = 0; i < SESSION_SLOTS; i++) begin
      hit[i]    = (int'(session_i) == i);
      expire[i] = 1'b0;
      age_d[i]  = age_q[i];
      case (cmd_e'(command_i))
        CMD_TICK: begin
          aged = (valid_q[i] && age_q[i] != AGE_TOP) ? age_q[i] + AGE_BITS'(1) : age_q[i];
          expire[i] = check_i && valid_q[i] &&
                      (CMP_BITS'(aged) >= CMP_BITS'(timeout_i));
          age_d[i]   = expire[i] ? '0 : aged;
          valid_d[i] = valid_q[i] && !expire[i];
        end
        CMD_FEED: begin
          if (hit[i]) begin
            valid_d[i] = 1'b1;
            age_d[i]   = '0;
          end
        end
        CMD_UNREG: begin
          if (hit[i]) begin
            valid_d[i] = 1'b0;
            age_d[i]   = '0;
          end
        end
        default: ;
      endcase
      removed = removed + COUNT_BITS'(expire[i]);
    end
    status_o.present    = |valid_q;
    status_o.survivor   = |(valid_q & ~expire);
    status_o.any_active = |valid_d;
    status_o.removed    = removed;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      for (int i = 0; i < SESSION_SLOTS; i++) begin
        age_q[i] <= '0;
      end
    end else if (en_i) begin
      valid_q <= valid_d;
      for (int i = 0; i < SESSION_SLOTS; i++) begin
        age_q[i] <= age_d[i];
      end
    end
  end

endmodule

FILE: hdl/multi_session_heartbeat_watchdog_core.sv
// Top level: multi-session heartbeat watchdog core.
`timescale 1ns / 1ps
//
//  Channel  Dir  Modport  Payload
//  cmd_i    in   sink     command[1:0], session[2:0]
//  res_o    out  source   heartbeat_pulse, emergency_stop, emergency_latched,
//                         any_active, expired_count[3:0]
//  cfg_i    in   sink     index[3:0] (0 timeout, 1 check period), data[15:0]
//
//  One transaction per cycle sustained while results are taken; each command passes
//  through the input register, then the result register.
//  All slots are compared against the timeout in parallel in the process stage.
//  Reset empties the table, clears the check counter and the emergency latch,
//  and loads timeout 200 and check period 50. No clearing pass is needed.
//  A stalled result holds the result register; the input register still takes
//  one more command, then cmd_i.ready drops until the result is taken.
//
module multi_session_heartbeat_watchdog_core
  import msw_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  msw_cmd_if.sink     cmd_i,
  msw_res_if.source   res_o,
  msw_cfg_if.sink     cfg_i
);

  // Configuration registers; always ready
  logic [CFG_BITS-1:0] timeout_q, period_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= TIMEOUT_RESET;
      period_q  <= PERIOD_RESET;
    end else if (cfg_i.valid) begin
      case (reg_idx_e'(cfg_i.index))
        REG_TIMEOUT: timeout_q <= cfg_i.data;
        REG_PERIOD:  period_q  <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // Input register
  logic                    in_valid_q;
  logic [CMD_BITS-1:0]     cmd_q;
  logic [SESSION_BITS-1:0] sess_q;
  logic                    advance;   // result register can take a new result
  logic                    process;   // buffered command is executed this cycle
  logic                    in_take;

  assign advance     = !res_o.valid || res_o.ready;
  assign process     = in_valid_q && advance;
  assign cmd_i.ready = !in_valid_q || advance;
  assign in_take     = cmd_i.valid && cmd_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (process) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      cmd_q  <= cmd_i.command;
      sess_q <= cmd_i.session;
    end
  end

  // Process stage
  logic         is_tick, is_feed;
  logic         check;
  slot_status_t status;

  always_comb begin
    is_tick = (cmd_e'(cmd_q) == CMD_TICK);
    // session index must name an existing slot
    is_feed = (cmd_e'(cmd_q) == CMD_FEED) && (int'(sess_q) < SESSION_SLOTS);
  end

  msw_check_timer u_timer (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .tick_i   (process && is_tick),
    .period_i (period_q),
    .check_o  (check)
  );

  msw_slot_table u_slots (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (process),
    .command_i (cmd_q),
    .session_i (sess_q),
    .check_i   (check),
    .timeout_i (timeout_q),
    .status_o  (status)
  );

  // Emergency latch: a check that empties a populated table fires once
  logic estop_q, estop_d;
  logic fire;

  always_comb begin
    fire    = check && status.present && !status.survivor && !estop_q;
    estop_d = estop_q;
    if (is_feed) begin
      estop_d = 1'b0;
    end else if (fire) begin
      estop_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      estop_q <= 1'b0;
    end else if (process) begin
      estop_q <= estop_d;
    end
  end

  // Result register
  logic                res_valid_q;
  logic                pulse_q, stop_q, latched_q, active_q;
  logic [EXP_BITS-1:0] expired_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (process) begin
      res_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (process) begin
      pulse_q   <= is_feed;
      stop_q    <= fire;
      latched_q <= estop_d;
      active_q  <= status.any_active;
      expired_q <= EXP_BITS'(status.removed);
    end
  end

  assign res_o.valid             = res_valid_q;
  assign res_o.heartbeat_pulse   = pulse_q;
  assign res_o.emergency_stop    = stop_q;
  assign res_o.emergency_latched = latched_q;
  assign res_o.any_active        = active_q;
  assign res_o.expired_count     = expired_q;

endmodule
